/* src/sih_pkg.sv */
`default_nettype none
package sih_pkg;
	localparam logic [63:0] HASH_BASIS = 64'd1469598103934665603;
	localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_CLEAR,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_LEN_CHK,
		S_CMP_RD,
		S_CMP_CHK,
		S_COPY,
		S_INSERT,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic mul_go;
		logic mul_step;
		logic clr_step;
		logic absorb;
		logic probe_init;
		logic bkt_rd;
		logic probe_next;
		logic len_rd;
		logic cmp_init;
		logic cmp_rd;
		logic cmp_next;
		logic copy_step;
		logic insert;
		logic emit;
		logic [1:0] emit_status;
		logic emit_hit;
		logic key_clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mul_done;
		logic clr_done;
		logic too_long;
		logic bkt_empty;
		logic len_match;
		logic cmp_done;
		logic byte_match;
		logic copy_done;
		logic full;
	} sts_t;
endpackage
`default_nettype wire

/* src/string_intern_hash_table.sv */
// Channel  | Ports                                | Handshake
// request  | key_byte, has_byte, last_byte        | start high, busy low
// result   | symbol_index, was_new, status        | done strobe, one cycle
// Each byte runs a 64x64 FNV multiply done as four 64x16 slices.
// A last item then probes occupied buckets, comparing the length and then
// each byte, until a match or an empty bucket ends the search; a new name is
// then copied and inserted unless the table is full, and a too-long name
// ends at once. done follows. After reset a clearing pass over all N_BUCKETS
// buckets empties the bucket table; busy stays high meanwhile. The receiver cannot stall.
`default_nettype none
module string_intern_hash_table #(
	parameter int N_BUCKETS = 1024,
	parameter int MAX_NAME_LEN = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire  [7:0] key_byte,
	input  wire        has_byte,
	input  wire        last_byte,
	output logic       done,
	output logic [9:0] symbol_index,
	output logic       was_new,
	output logic [1:0] status
);
	import sih_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sih_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .has_byte(has_byte),
		.last_byte(last_byte), .sts(sts), .busy(busy), .cmd(cmd)
	);

	sih_dp #(.N_BUCKETS(N_BUCKETS), .MAX_NAME_LEN(MAX_NAME_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .key_byte(key_byte), .cmd(cmd), .sts(sts),
		.symbol_index(symbol_index), .was_new(was_new), .status(status),
		.done(done)
	);
endmodule
`default_nettype wire

/* src/sih_ctrl.sv */
`default_nettype none
module sih_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               has_byte,
	input  wire               last_byte,
	input  sih_pkg::sts_t     sts,
	output logic              busy,
	output sih_pkg::cmd_t     cmd
);
	import sih_pkg::*;

	state_t state_q, state_d;
	logic   last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		last_d  = last_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					last_d = last_byte;
					if (has_byte) begin
						cmd.absorb = 1'b1;
						cmd.mul_go = 1'b1;
						state_d = S_MUL;
					end else if (last_byte) begin
						state_d = S_PROBE_RD;
						cmd.probe_init = 1'b1;
					end
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_done) begin
					if (last_q) begin
						cmd.probe_init = 1'b1;
						state_d = S_PROBE_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_PROBE_RD: begin
				if (sts.too_long) begin
					cmd.emit = 1'b1;
					cmd.emit_status = ST_TOO_LONG;
					cmd.key_clear = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.bkt_rd = 1'b1;
					state_d = S_PROBE_CHK;
				end
			end
			S_PROBE_CHK: begin
				if (sts.bkt_empty) begin
					if (sts.full) begin
						cmd.emit = 1'b1;
						cmd.emit_status = ST_FULL;
						cmd.key_clear = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.cmp_init = 1'b1;
						state_d = S_COPY;
					end
				end else begin
					cmd.len_rd = 1'b1;
					state_d = S_LEN_CHK;
				end
			end
			S_LEN_CHK: begin
				cmd.cmp_init = 1'b1;
				if (sts.len_match) begin
					state_d = S_CMP_RD;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = S_PROBE_RD;
				end
			end
			S_CMP_RD: begin
				if (sts.cmp_done) begin
					cmd.emit = 1'b1;
					cmd.emit_hit = 1'b1;
					cmd.emit_status = ST_OK;
					cmd.key_clear = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.cmp_rd = 1'b1;
					state_d = S_CMP_CHK;
				end
			end
			S_CMP_CHK: begin
				if (sts.byte_match) begin
					cmd.cmp_next = 1'b1;
					state_d = S_CMP_RD;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = S_PROBE_RD;
				end
			end
			S_COPY: begin
				if (sts.copy_done) begin
					state_d = S_INSERT;
				end else begin
					cmd.copy_step = 1'b1;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				cmd.emit = 1'b1;
				cmd.emit_status = ST_OK;
				cmd.key_clear = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* src/sih_dp.sv */
`default_nettype none
module sih_dp #(
	parameter int N_BUCKETS = 1024,
	parameter int MAX_NAME_LEN = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [7:0]        key_byte,
	input  sih_pkg::cmd_t     cmd,
	output sih_pkg::sts_t     sts,
	output logic [9:0]        symbol_index,
	output logic              was_new,
	output logic [1:0]        status,
	output logic              done
);
	import sih_pkg::*;

	localparam int RECORD_CAP = (N_BUCKETS * 7) / 8;
	localparam int BW = $clog2(N_BUCKETS);
	localparam int KW = $clog2(MAX_NAME_LEN);
	localparam int LW = $clog2(MAX_NAME_LEN + 1);
	localparam int RW = $clog2(RECORD_CAP + 1);
	localparam int NW = $clog2(RECORD_CAP * MAX_NAME_LEN);

	// hash and key state
	logic [63:0]   hash_q, acc_q, mcand_q;
	logic [1:0]    mcnt_q;
	logic [LW-1:0] klen_q;
	logic          tlong_q;

	// stores
	logic [RW-1:0] bkt_mem [N_BUCKETS];
	logic [7:0]    key_mem [MAX_NAME_LEN];
	logic [7:0]    name_mem [RECORD_CAP * MAX_NAME_LEN];
	logic [LW-1:0] len_mem [RECORD_CAP];

	logic [BW-1:0] clr_q, pos_q;
	logic [RW-1:0] bkt_rd_q, cnt_q;
	logic [LW-1:0] len_rd_q, ci_q, cpy_ci_q;
	logic          cpy_v_q;
	logic [7:0]    key_rd_q, name_rd_q;
	logic [RW-1:0] rec;

	// 64x64 low product in four 64x16 slices, summed into acc_q in order of mcnt_q
	logic [15:0] pslice;
	logic [63:0] part;
	logic [63:0] hash_nx;
	always_comb begin
		case (mcnt_q)
			2'd0:    pslice = HASH_PRIME[15:0];
			2'd1:    pslice = HASH_PRIME[31:16];
			2'd2:    pslice = HASH_PRIME[47:32];
			default: pslice = HASH_PRIME[63:48];
		endcase
		part = 64'(mcand_q * 64'(pslice)) << (6'(mcnt_q) * 6'd16);
		hash_nx = acc_q + part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= HASH_BASIS;
			klen_q  <= '0;
			tlong_q <= 1'b0;
			mcnt_q  <= '0;
			clr_q   <= '0;
			cnt_q   <= '0;
			cpy_v_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= cmd.emit;
			cpy_v_q <= cmd.copy_step;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.absorb) begin
				if (klen_q < LW'(MAX_NAME_LEN)) klen_q <= klen_q + 1'b1;
				else tlong_q <= 1'b1;
			end
			if (cmd.mul_go) mcnt_q <= '0;
			else if (cmd.mul_step) begin
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q == 2'd3) hash_q <= hash_nx;
			end
			if (cmd.insert) cnt_q <= cnt_q + 1'b1;
			if (cmd.key_clear) begin
				hash_q  <= HASH_BASIS;
				klen_q  <= '0;
				tlong_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			mcand_q <= hash_q ^ {56'd0, key_byte};
			acc_q   <= '0;
		end else if (cmd.mul_step) begin
			acc_q <= acc_q + part;
		end
		if (cmd.absorb && klen_q < LW'(MAX_NAME_LEN))
			key_mem[klen_q[KW-1:0]] <= key_byte;
		// a probe starting on the last multiply cycle takes the hash being formed
		if (cmd.probe_init)
			pos_q <= (cmd.mul_step && mcnt_q == 2'd3) ? hash_nx[BW-1:0] : hash_q[BW-1:0];
		else if (cmd.probe_next) pos_q <= pos_q + 1'b1;
		if (cmd.cmp_init) ci_q <= '0;
		else if (cmd.cmp_next || cmd.copy_step) ci_q <= ci_q + 1'b1;
	end

	// bucket table: one write port, one registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_step) bkt_mem[clr_q] <= '0;
		else if (cmd.insert) bkt_mem[pos_q] <= cnt_q + 1'b1;
		if (cmd.bkt_rd) bkt_rd_q <= bkt_mem[pos_q];
	end

	assign rec = bkt_rd_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.insert) len_mem[cnt_q] <= klen_q;
		if (cmd.len_rd) len_rd_q <= len_mem[rec];
	end

	// name bytes; copy writes record cnt_q in the cycle after its key read,
	// compare reads record rec
	logic [NW-1:0] rd_addr, wr_addr;
	assign rd_addr = NW'(rec) * NW'(MAX_NAME_LEN) + NW'(ci_q);
	assign wr_addr = NW'(cnt_q) * NW'(MAX_NAME_LEN) + NW'(cpy_ci_q);
	always_ff @(posedge clk) begin
		if (cmd.cmp_rd || cmd.copy_step) key_rd_q <= key_mem[ci_q[KW-1:0]];
		if (cmd.copy_step) cpy_ci_q <= ci_q;
		if (cpy_v_q) name_mem[wr_addr] <= key_rd_q;
		if (cmd.cmp_rd) name_rd_q <= name_mem[rd_addr];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= cmd.emit_status;
			was_new <= cmd.insert;
			if (cmd.insert) symbol_index <= 10'(cnt_q);
			else if (cmd.emit_hit) symbol_index <= 10'(rec);
			else symbol_index <= '0;
		end
	end

	always_comb begin
		sts.mul_done   = cmd.mul_step && mcnt_q == 2'd3;
		sts.clr_done   = clr_q == {BW{1'b1}};
		sts.too_long   = tlong_q;
		sts.bkt_empty  = bkt_rd_q == '0;
		sts.len_match  = len_rd_q == klen_q;
		sts.cmp_done   = ci_q == klen_q;
		sts.byte_match = name_rd_q == key_rd_q;
		sts.copy_done  = ci_q == klen_q;
		sts.full       = (32'(cnt_q) + 32'd1) * 32'd8 >= 32'(N_BUCKETS) * 32'd7;
	end
endmodule
`default_nettype wire

/* test/string_intern_hash_table_test.sv */
`default_nettype none
module string_intern_hash_table_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sih_pkg::*;

	localparam int BUCKETS = 1024;
	localparam int NAME_MAX = 64;
	localparam int REC_CAP = (BUCKETS * 7) / 8;

	typedef struct {
		logic [7:0] kb;
		logic       hb;
		logic       lb;
		int         phase;
	} request_t;

	typedef struct {
		logic [9:0] index;
		logic       fresh;
		logic [1:0] code;
	} lookup_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] key_byte;
	logic       has_byte;
	logic       last_byte;
	logic       done;
	logic [9:0] symbol_index;
	logic       was_new;
	logic [1:0] status;

	string_intern_hash_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.key_byte(key_byte), .has_byte(has_byte), .last_byte(last_byte),
		.done(done), .symbol_index(symbol_index), .was_new(was_new), .status(status)
	);

	request_t pending_requests[$];
	lookup_t  expected_lookups[$];
	int       failures = 0;
	int       n_new = 0, n_hit = 0, n_full = 0, n_long = 0;
	bit       stimulus_done = 0;

	// mirror of the table
	logic [63:0] hash_acc;
	logic [7:0]  key_buf[NAME_MAX];
	int          key_len;
	bit          overlong;
	int          bucket_of[BUCKETS];
	logic [7:0]  stored_name[REC_CAP][NAME_MAX];
	int          stored_len[REC_CAP];
	int          interned;

	// name history used by the generator
	logic [7:0]  sent_name[4000][NAME_MAX];
	int          sent_len[4000];
	int          sent_count = 0;
	bit          known_key[string];
	int          distinct_fresh = 0;
	int          items = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic bit record_equal(int rec);
		if (stored_len[rec] != key_len)
			return 0;
		for (int i = 0; i < key_len; i++)
			if (stored_name[rec][i] != key_buf[i])
				return 0;
		return 1;
	endfunction

	// fold one request into the mirror; push an expectation at a last mark
	task automatic intern_predict(request_t r);
		lookup_t e;
		int pos, v;
		bit hit, empty;
		pos = 0;
		hit = 0;
		empty = 0;
		e = '{index: '0, fresh: 1'b0, code: ST_OK};
		if (r.hb) begin
			hash_acc = (hash_acc ^ {56'd0, r.kb}) * HASH_PRIME;
			if (key_len < NAME_MAX) begin
				key_buf[key_len] = r.kb;
				key_len++;
			end else
				overlong = 1;
		end
		if (!r.lb)
			return;
		if (overlong)
			e.code = ST_TOO_LONG;
		else begin
			pos = int'(hash_acc[9:0]);
			for (int s = 0; s < BUCKETS; s++) begin
				v = bucket_of[pos];
				if (v == 0) begin
					empty = 1;
					break;
				end
				if (record_equal(v - 1)) begin
					hit = 1;
					e.index = 10'(v - 1);
					break;
				end
				pos = (pos + 1) % BUCKETS;
			end
			if (!hit) begin
				if ((interned + 1) * 8 >= BUCKETS * 7 || !empty || interned >= REC_CAP)
					e.code = ST_FULL;
				else begin
					for (int i = 0; i < key_len; i++)
						stored_name[interned][i] = key_buf[i];
					stored_len[interned] = key_len;
					bucket_of[pos] = interned + 1;
					e.index = 10'(interned);
					e.fresh = 1;
					interned++;
				end
			end
		end
		expected_lookups.push_back(e);
		hash_acc = HASH_BASIS;
		key_len = 0;
		overlong = 0;
	endtask

	// driver
	int active_phase = 0;
	request_t cur;
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
			key_byte <= '0;
			has_byte <= 1'b0;
			last_byte <= 1'b0;
		end else begin
			if (start && !busy)
				intern_predict(cur);
			if (!start || !busy) begin
				if (pending_requests.size() > 0 &&
				    (pending_requests[0].phase == active_phase ||
				     expected_lookups.size() == 0)) begin
					// a new phase only begins once the table has caught up
					active_phase = pending_requests[0].phase;
					idle_pct = (active_phase == 1) ? 13 : (active_phase == 2) ? 50 : 0;
					if ($urandom_range(0, 99) < idle_pct)
						start <= 1'b0;
					else begin
						cur = pending_requests.pop_front();
						start <= 1'b1;
						key_byte <= cur.kb;
						has_byte <= cur.hb;
						last_byte <= cur.lb;
					end
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		lookup_t e;
		if (arst_n && done) begin
			if (expected_lookups.size() == 0) begin
				$error("result with nothing outstanding: index %0d new %0b status %0d",
					symbol_index, was_new, status);
				failures++;
			end else begin
				e = expected_lookups.pop_front();
				if (symbol_index !== e.index) begin
					$error("symbol_index: expected %0d, got %0d", e.index, symbol_index);
					failures++;
				end
				if (was_new !== e.fresh) begin
					$error("was_new: expected %0b, got %0b", e.fresh, was_new);
					failures++;
				end
				if (status !== e.code) begin
					$error("status: expected %0d, got %0d", e.code, status);
					failures++;
				end
				case (e.code)
					ST_OK: if (e.fresh) n_new++; else n_hit++;
					ST_FULL: n_full++;
					default: n_long++;
				endcase
			end
		end
	end

	task automatic queue_name(logic [7:0] nm[NAME_MAX + 8], int len, int ph,
		bit noise, bit bare_last);
		string k;
		k = "";
		for (int i = 0; i < len; i++) begin
			if (noise && $urandom_range(0, 9) == 0) begin
				pending_requests.push_back('{kb: 8'($urandom), hb: 1'b0, lb: 1'b0, phase: ph});
			end
			pending_requests.push_back('{kb: nm[i], hb: 1'b1,
				lb: (i == len - 1) && !bare_last, phase: ph});
			items++;
			k = $sformatf("%s%02x", k, nm[i]);
		end
		if (len == 0 || bare_last) begin
			pending_requests.push_back('{kb: 8'($urandom), hb: 1'b0, lb: 1'b1, phase: ph});
			items++;
		end
		if (len <= NAME_MAX && sent_count < 4000) begin
			for (int i = 0; i < len; i++)
				sent_name[sent_count][i] = nm[i];
			sent_len[sent_count] = len;
			sent_count++;
			if (!known_key.exists(k)) begin
				known_key[k] = 1;
				distinct_fresh++;
			end
		end
	endtask

	initial begin
		logic [7:0] nm[NAME_MAX + 8];
		int len, kind, pick, ph;
		hash_acc = HASH_BASIS;
		key_len = 0;
		overlong = 0;
		interned = 0;
		foreach (bucket_of[i]) bucket_of[i] = 0;
		start = 1'b0;
		key_byte = '0;
		has_byte = 1'b0;
		last_byte = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b0;
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty name, extreme bytes, bare last, length limits, repeats
		queue_name(nm, 0, 0, 0, 0);
		nm[0] = 8'h00; queue_name(nm, 1, 0, 0, 0);
		nm[0] = 8'hff; queue_name(nm, 1, 0, 0, 0);
		nm[0] = 8'h00; queue_name(nm, 1, 0, 0, 0);
		nm[0] = 8'h41; nm[1] = 8'h42; queue_name(nm, 2, 0, 1, 1);
		pending_requests.push_back('{kb: 8'hff, hb: 1'b0, lb: 1'b0, phase: 0});
		queue_name(nm, 0, 0, 0, 0);
		nm[0] = 8'h41; nm[1] = 8'h42; queue_name(nm, 2, 0, 0, 0);
		for (int i = 0; i < NAME_MAX + 1; i++) nm[i] = 8'(i * 37 + 1);
		queue_name(nm, NAME_MAX, 0, 0, 0);
		queue_name(nm, NAME_MAX + 1, 0, 0, 0);
		queue_name(nm, NAME_MAX, 0, 0, 1);
		queue_name(nm, NAME_MAX, 0, 0, 0);

		// random: mostly short fresh names, plus repeats and junk
		while (items < 1300) begin
			ph = (items < 600) ? 1 : (items < 950) ? 2 : 3;
			kind = $urandom_range(0, 99);
			if (kind < 62) begin
				len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 3);
				for (int i = 0; i < len; i++) nm[i] = 8'($urandom);
			end else if (kind < 82) begin
				pick = $urandom_range(0, sent_count - 1);
				len = sent_len[pick];
				for (int i = 0; i < len; i++) nm[i] = sent_name[pick][i];
			end else if (kind < 88) begin
				len = $urandom_range(NAME_MAX + 1, NAME_MAX + 8);
				for (int i = 0; i < len; i++) nm[i] = 8'($urandom);
			end else if (kind < 91) begin
				len = 0;
			end else begin
				len = $urandom_range(4, NAME_MAX);
				for (int i = 0; i < len; i++) nm[i] = 8'($urandom);
			end
			queue_name(nm, len, ph, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
		end
		stimulus_done = 1;

		while (pending_requests.size() != 0 || start) @(posedge clk);
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("%0d request items; lookups: %0d new, %0d found, %0d table full, %0d too long",
			items, n_new, n_hit, n_full, n_long);
		$display("ran with sender idling at 13%%, 50%% and 0%%, with repeats, empty names and overlong names");
		if (failures == 0 && expected_lookups.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#30ms;
		$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
src/sih_pkg.sv
src/sih_ctrl.sv
src/sih_dp.sv
src/string_intern_hash_table.sv
test/string_intern_hash_table_test.sv
